/* hw/rtl/owbm_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the one-wire bus master
package owbm_pkg;

    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned COUNT_W    = 10;

    localparam logic [9:0] RESET_LOW_DEF       = 10'd480;
    localparam logic [9:0] PRESENCE_SAMPLE_DEF = 10'd60;
    localparam logic [9:0] RESET_RECOVER_DEF   = 10'd480;
    localparam logic [6:0] WRITE_ONE_LOW_DEF   = 7'd6;
    localparam logic [6:0] WRITE_ZERO_LOW_DEF  = 7'd60;
    localparam logic [6:0] SLOT_DEF            = 7'd70;
    localparam logic [3:0] READ_LOW_DEF        = 4'd2;
    localparam logic [6:0] READ_SAMPLE_DEF     = 7'd4;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [9:0] reset_low_ticks;
        logic [9:0] presence_sample_ticks;
        logic [9:0] reset_recover_ticks;
        logic [6:0] write_one_low_ticks;
        logic [6:0] write_zero_low_ticks;
        logic [6:0] slot_ticks;
        logic [3:0] read_low_ticks;
        logic [6:0] read_sample_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic       line_level;
    } t_in_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       presence_level;
    } t_out_item;

endpackage

/* hw/rtl/owbm_regs.sv */
`timescale 1ns / 1ps
// apb register file holding the bus timing settings
module owbm_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [owbm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [owbm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [owbm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output owbm_pkg::t_cfg                     o_cfg
);

    typedef enum logic [2:0] {
        REG_RESET_LOW       = 3'd0,
        REG_PRESENCE_SAMPLE = 3'd1,
        REG_RESET_RECOVER   = 3'd2,
        REG_WRITE_ONE_LOW   = 3'd3,
        REG_WRITE_ZERO_LOW  = 3'd4,
        REG_SLOT            = 3'd5,
        REG_READ_LOW        = 3'd6,
        REG_READ_SAMPLE     = 3'd7
    } t_reg_idx;

    owbm_pkg::t_cfg r_cfg;
    t_reg_idx       w_idx;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks       <= owbm_pkg::RESET_LOW_DEF;
            r_cfg.presence_sample_ticks <= owbm_pkg::PRESENCE_SAMPLE_DEF;
            r_cfg.reset_recover_ticks   <= owbm_pkg::RESET_RECOVER_DEF;
            r_cfg.write_one_low_ticks   <= owbm_pkg::WRITE_ONE_LOW_DEF;
            r_cfg.write_zero_low_ticks  <= owbm_pkg::WRITE_ZERO_LOW_DEF;
            r_cfg.slot_ticks            <= owbm_pkg::SLOT_DEF;
            r_cfg.read_low_ticks        <= owbm_pkg::READ_LOW_DEF;
            r_cfg.read_sample_ticks     <= owbm_pkg::READ_SAMPLE_DEF;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_RESET_LOW:       r_cfg.reset_low_ticks       <= pwdata[9:0];
                REG_PRESENCE_SAMPLE: r_cfg.presence_sample_ticks <= pwdata[9:0];
                REG_RESET_RECOVER:   r_cfg.reset_recover_ticks   <= pwdata[9:0];
                REG_WRITE_ONE_LOW:   r_cfg.write_one_low_ticks   <= pwdata[6:0];
                REG_WRITE_ZERO_LOW:  r_cfg.write_zero_low_ticks  <= pwdata[6:0];
                REG_SLOT:            r_cfg.slot_ticks            <= pwdata[6:0];
                REG_READ_LOW:        r_cfg.read_low_ticks        <= pwdata[3:0];
                REG_READ_SAMPLE:     r_cfg.read_sample_ticks     <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_RESET_LOW:       prdata = {22'd0, r_cfg.reset_low_ticks};
            REG_PRESENCE_SAMPLE: prdata = {22'd0, r_cfg.presence_sample_ticks};
            REG_RESET_RECOVER:   prdata = {22'd0, r_cfg.reset_recover_ticks};
            REG_WRITE_ONE_LOW:   prdata = {25'd0, r_cfg.write_one_low_ticks};
            REG_WRITE_ZERO_LOW:  prdata = {25'd0, r_cfg.write_zero_low_ticks};
            REG_SLOT:            prdata = {25'd0, r_cfg.slot_ticks};
            REG_READ_LOW:        prdata = {28'd0, r_cfg.read_low_ticks};
            REG_READ_SAMPLE:     prdata = {25'd0, r_cfg.read_sample_ticks};
            default:             prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/owbm_engine.sv */
`timescale 1ns / 1ps
// bus sequencer: one tick transaction in, one result out
module owbm_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  owbm_pkg::t_cfg      i_cfg,
    input  owbm_pkg::t_in_item  i_item,
    output owbm_pkg::t_out_item o_result
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RESET = 2'd1,
        PH_WRITE = 2'd2,
        PH_READ  = 2'd3
    } t_phase;

    localparam logic [2:0] SEG_LOW     = 3'd0;
    localparam logic [2:0] SEG_WAIT    = 3'd1;
    localparam logic [2:0] SEG_RECOVER = 3'd2;
    localparam logic [2:0] LAST_BIT    = 3'd7;

    t_phase      r_phase, n_phase, w_phase;
    logic [9:0]  r_count, n_count, w_count;
    logic [2:0]  r_bit, n_bit, w_bit;
    logic [7:0]  r_shift, n_shift, w_shift;
    logic [7:0]  r_read, n_read;
    logic        r_presence, n_presence;
    logic        w_start, w_drive, w_done, w_last, w_low_bit;
    logic [10:0] w_inc;
    logic [6:0]  w_low;

    always_comb begin
        w_start = (r_phase == PH_IDLE) && (i_item.command != owbm_pkg::CMD_TICK);
        w_phase = w_start ? t_phase'(i_item.command) : r_phase;
        w_count = w_start ? '0 : r_count;
        w_bit   = w_start ? '0 : r_bit;
        w_shift = r_shift;
        if (w_start) begin
            w_shift = (i_item.command == owbm_pkg::CMD_WRITE) ? i_item.data_byte : 8'd0;
        end
        w_inc     = {1'b0, w_count} + 11'd1;
        w_last    = w_inc >= {4'd0, i_cfg.slot_ticks};
        w_low_bit = w_shift[0];
        w_low     = w_low_bit ? i_cfg.write_one_low_ticks : i_cfg.write_zero_low_ticks;

        n_phase    = w_phase;
        n_count    = w_inc[9:0];
        n_bit      = w_bit;
        n_shift    = w_shift;
        n_read     = r_read;
        n_presence = r_presence;
        w_drive    = 1'b0;
        w_done     = 1'b0;

        unique case (w_phase)
            PH_IDLE: begin
                n_count = w_count;
            end
            PH_RESET: begin
                if (w_bit == SEG_LOW) begin
                    w_drive = 1'b1;
                    if (w_inc >= {1'b0, i_cfg.reset_low_ticks}) begin
                        n_bit   = SEG_WAIT;
                        n_count = '0;
                    end
                end else if (w_bit == SEG_WAIT) begin
                    if (w_inc >= {1'b0, i_cfg.presence_sample_ticks}) begin
                        n_presence = i_item.line_level;
                        n_bit      = SEG_RECOVER;
                        n_count    = '0;
                    end
                end else begin
                    if (w_inc >= {1'b0, i_cfg.reset_recover_ticks}) begin
                        w_done  = 1'b1;
                        n_phase = PH_IDLE;
                        n_bit   = '0;
                        n_count = '0;
                    end
                end
            end
            PH_WRITE, PH_READ: begin
                if (w_phase == PH_WRITE) begin
                    w_drive = w_count < {3'd0, w_low};
                    if (w_last) begin
                        n_shift = {1'b0, w_shift[7:1]};
                    end
                end else begin
                    w_drive = w_count < {6'd0, i_cfg.read_low_ticks};
                    if ((w_count == {3'd0, i_cfg.read_sample_ticks}) ||
                        (w_last && (w_count < {3'd0, i_cfg.read_sample_ticks}))) begin
                        n_shift = {i_item.line_level, w_shift[7:1]};
                    end
                end
                if (w_last) begin
                    n_count = '0;
                    if (w_bit == LAST_BIT) begin
                        if (w_phase == PH_READ) begin
                            n_read = n_shift;
                        end
                        w_done  = 1'b1;
                        n_phase = PH_IDLE;
                        n_bit   = '0;
                    end else begin
                        n_bit = w_bit + 3'd1;
                    end
                end
            end
            default: ;
        endcase

        o_result.drive_low      = w_drive;
        o_result.busy_res       = (w_phase != PH_IDLE);
        o_result.done_res       = w_done;
        o_result.read_data      = n_read;
        o_result.presence_level = n_presence;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_count    <= '0;
            r_bit      <= '0;
            r_shift    <= '0;
            r_read     <= '0;
            r_presence <= 1'b1;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_read     <= n_read;
            r_presence <= n_presence;
        end
    end

endmodule

/* hw/rtl/one_wire_bus_master.sv */
`timescale 1ns / 1ps
// one-wire bus master top level
//
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_ready    i_in_item  (command, data_byte, line_level)
//  out      output     o_out_valid / i_out_ready  o_out_item (drive_low .. presence_level)
//  cfg      input      psel penable pwrite pready paddr, pwdata, prdata
//
//  one tick transaction is taken per clock unless a stalled result holds it off; its result
//  is registered, shown the cycle after acceptance, with sequencer state updated at that edge
//  synchronous active-low reset puts the sequencer idle and the timing registers
//  at their defaults; no clearing pass is needed
//  a stalled result holds the output register and the input side waits with it
module one_wire_bus_master (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  owbm_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output owbm_pkg::t_out_item               o_out_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [owbm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [owbm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [owbm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    owbm_pkg::t_cfg      w_cfg;
    owbm_pkg::t_out_item w_result;
    owbm_pkg::t_out_item r_out_item;
    logic                r_out_valid;
    logic                w_accept;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    owbm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    owbm_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_accept),
        .i_cfg    (w_cfg),
        .i_item   (i_in_item),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_item <= w_result;
        end
    end

endmodule

/* hw/rtl/owbm_checker.sv */
`timescale 1ns / 1ps
// port-level checks for the one-wire bus master, bound to the top level
module owbm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input owbm_pkg::t_out_item o_out_item
);

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted transaction produced no result");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.done_res) |-> o_out_item.busy_res)
        else $error("done without busy");

    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.busy_res) |-> !o_out_item.drive_low)
        else $error("bus driven low while idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
